FILE: hw/rtl/srpda_pkg.sv
// Shared constants, codes and types of the sparse row dot accumulator.
package srpda_pkg;

    // Field widths of one input item and one result item
    localparam int FUNC_W = 2;
    localparam int IDX_W  = 10;
    localparam int DATA_W = 8;
    localparam int MODE_W = 2;
    localparam int OUT_W  = 32;

    // Lane product of mode 0 fits in 17 signed bits (-128 * 255)
    localparam int PROD_W = 17;

    // Defaults of the top level parameters
    localparam int VECTOR_DEPTH_DEF = 1024;
    localparam int ACC_WIDTH_DEF    = 32;

    // Decoupling queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Item kinds; the fourth code is ignored
    localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_NONZERO = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_EMPTY   = 2'd2;

    // Precision modes; every other code selects two 4-bit lanes
    localparam logic [MODE_W-1:0] MODE_INT8 = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INT2 = 2'd1;

    // One operation handed from front to back
    typedef struct packed {
        logic              is_empty;
        logic [DATA_W-1:0] val;
        logic [DATA_W-1:0] vec;
        logic              last;
    } srpda_op_t;

    typedef struct packed {
        logic      valid;
        srpda_op_t op;
    } srpda_entry_t;

endpackage

FILE: hw/rtl/srpda_ram.sv
// Generic single write port, single read port RAM with registered read data.
module srpda_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/srpda_front.sv
// Front end: accepts items, folds the index into the store, runs loads and vector reads.
module srpda_front #(
    parameter int VECTOR_DEPTH = srpda_pkg::VECTOR_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [srpda_pkg::FUNC_W-1:0]     in_func,
    input  logic [srpda_pkg::IDX_W-1:0]      in_index,
    input  logic [srpda_pkg::DATA_W-1:0]     in_data,
    input  logic                             in_last,
    input  logic [srpda_pkg::QCNT_W-1:0]     q_count,
    output srpda_pkg::srpda_entry_t          push
);
    import srpda_pkg::*;

    localparam int AW      = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
    localparam int DEPTH_W = $clog2(VECTOR_DEPTH + 1);
    localparam int RECIP_W = 12;
    localparam longint unsigned SHIFT = IDX_W + AW;
    // ceil(2^SHIFT / depth): exact quotient for every 10-bit index
    localparam longint unsigned RECIP =
        ((64'd1 << SHIFT) + VECTOR_DEPTH - 1) / VECTOR_DEPTH;
    localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);
    localparam logic [DEPTH_W-1:0] DEPTH_C = DEPTH_W'(VECTOR_DEPTH);

    // stage A: accepted item plus quotient index / depth
    logic                  a_valid_reg, a_valid_next;
    logic [FUNC_W-1:0]     a_func_reg;
    logic [IDX_W-1:0]      a_index_reg;
    logic [DATA_W-1:0]     a_data_reg;
    logic                  a_last_reg;
    logic [IDX_W-1:0]      a_q_reg;

    // stage B: operation waiting on the RAM read data
    logic                  b_valid_reg, b_valid_next;
    logic                  b_empty_reg;
    logic [DATA_W-1:0]     b_val_reg;
    logic                  b_last_reg;

    logic                  accept;
    logic [IDX_W+RECIP_W-1:0] q_prod;
    logic [IDX_W+DEPTH_W-1:0] qd_prod;
    logic [IDX_W+DEPTH_W-1:0] rem_full;
    logic [AW-1:0]         addr;
    logic                  ram_we, ram_re;
    logic [DATA_W-1:0]     ram_rdata;
    logic [QCNT_W:0]       pending;

    // room for everything in flight plus one more item
    assign pending  = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(a_valid_reg)
                    + (QCNT_W+1)'(b_valid_reg);
    assign s_tready = (pending < (QCNT_W+1)'(QUEUE_DEPTH));
    assign accept   = s_tvalid && s_tready;

    assign q_prod   = (IDX_W+RECIP_W)'(in_index) * (IDX_W+RECIP_W)'(RECIP_C);
    assign qd_prod  = (IDX_W+DEPTH_W)'(a_q_reg) * (IDX_W+DEPTH_W)'(DEPTH_C);
    assign rem_full = (IDX_W+DEPTH_W)'(a_index_reg) - qd_prod;
    assign addr     = rem_full[AW-1:0];

    assign ram_we = a_valid_reg && (a_func_reg == FUNC_LOAD);
    assign ram_re = a_valid_reg && (a_func_reg == FUNC_NONZERO);

    assign a_valid_next = accept;
    assign b_valid_next = a_valid_reg &&
                          ((a_func_reg == FUNC_NONZERO) || (a_func_reg == FUNC_EMPTY));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
        if (accept) begin
            a_func_reg  <= in_func;
            a_index_reg <= in_index;
            a_data_reg  <= in_data;
            a_last_reg  <= in_last;
            a_q_reg     <= IDX_W'(q_prod >> SHIFT);
        end
        if (a_valid_reg) begin
            b_empty_reg <= (a_func_reg == FUNC_EMPTY);
            b_val_reg   <= a_data_reg;
            b_last_reg  <= a_last_reg;
        end
    end

    srpda_ram #(
        .WIDTH (DATA_W),
        .DEPTH (VECTOR_DEPTH)
    ) u_vec_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (addr),
        .wr_data (a_data_reg),
        .rd_en   (ram_re),
        .rd_addr (addr),
        .rd_data (ram_rdata)
    );

    always_comb begin
        push             = '0;
        push.valid       = b_valid_reg;
        push.op.is_empty = b_empty_reg;
        push.op.val      = b_val_reg;
        push.op.vec      = ram_rdata;
        push.op.last     = b_last_reg;
    end

endmodule

FILE: hw/rtl/srpda_queue.sv
// Short register queue that decouples the front end from the accumulate stage.
module srpda_queue (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  srpda_pkg::srpda_entry_t       push,
    input  logic                          pop,
    output srpda_pkg::srpda_entry_t       head,
    output logic [srpda_pkg::QCNT_W-1:0]  count
);
    import srpda_pkg::*;

    srpda_op_t          slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_pop;

    assign do_pop = pop && (count_reg != '0);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid) begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        end
        case ({push.valid, do_pop})
            2'b10:   count_next = count_reg + QCNT_W'(1);
            2'b01:   count_next = count_reg - QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push.valid) begin
            slots[wr_ptr_reg] <= push.op;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.op    = slots[rd_ptr_reg];
    assign count      = count_reg;

endmodule

FILE: hw/rtl/srpda_back.sv
// Back end: lane multiply, row accumulate and the result output register.
module srpda_back #(
    parameter int ACC_WIDTH = srpda_pkg::ACC_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [srpda_pkg::MODE_W-1:0]  mode,
    input  srpda_pkg::srpda_entry_t       head,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [srpda_pkg::OUT_W-1:0]   m_tdata
);
    import srpda_pkg::*;

    // Sum of lane products under the precision mode; in the 2-bit and 4-bit modes each lane product wraps to lane width
    function automatic logic signed [PROD_W-1:0] lane_product(
        input logic [MODE_W-1:0] md,
        input logic [DATA_W-1:0] a,
        input logic [DATA_W-1:0] b
    );
        logic signed [PROD_W-1:0] s;
        logic signed [1:0]        a2, b2;
        logic signed [3:0]        p2;
        logic signed [3:0]        a4, b4;
        logic signed [7:0]        p4;
        s = '0;
        case (md)
            MODE_INT8: begin
                s = signed'({{(PROD_W-DATA_W){a[DATA_W-1]}}, a})
                  * signed'({{(PROD_W-DATA_W){1'b0}}, b});
            end
            MODE_INT2: begin
                for (int i = 0; i < 4; i++) begin
                    a2 = a[2*i +: 2];
                    b2 = b[2*i +: 2];
                    p2 = a2 * b2;
                    s  = s + PROD_W'(signed'(p2[1:0]));
                end
            end
            default: begin
                for (int i = 0; i < 2; i++) begin
                    a4 = a[4*i +: 4];
                    b4 = b[4*i +: 4];
                    p4 = a4 * b4;
                    s  = s + PROD_W'(signed'(p4[3:0]));
                end
            end
        endcase
        return s;
    endfunction

    logic signed [ACC_WIDTH-1:0] acc_reg, acc_next;
    logic signed [ACC_WIDTH-1:0] acc_sum;
    logic signed [PROD_W-1:0]    prod;
    logic                        m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]            m_data_reg, m_data_next;
    logic                        needs_out;

    assign needs_out = head.op.is_empty || head.op.last;
    assign pop       = head.valid && (!needs_out || !m_valid_reg || m_tready);

    assign prod    = lane_product(mode, head.op.val, head.op.vec);
    assign acc_sum = acc_reg + ACC_WIDTH'(prod);

    always_comb begin
        acc_next     = acc_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        if (pop) begin
            if (head.op.is_empty) begin
                // empty row leaves a partial row sum untouched
                m_valid_next = 1'b1;
                m_data_next  = '0;
            end else if (head.op.last) begin
                m_valid_next = 1'b1;
                m_data_next  = OUT_W'(acc_sum);
                acc_next     = '0;
            end else begin
                acc_next     = acc_sum;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            acc_reg     <= acc_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

FILE: hw/rtl/sparse_row_packed_dot_accumulator.sv
// Top level of the sparse row dot accumulator: front end, queue, back end, mode register.
// Path: an input item passes stage A, stage B, the queue and the output register before its result is valid.
// Throughput: one input item per cycle while s_tready is high; the front end pipeline and the vector RAM
// (one access per item) take one item each cycle, and s_tready drops when a stalled output fills the queue.
// Reset: synchronous, active low aresetn clears the pipeline, the queue, the row
// accumulator, the output register and precision_mode; the vector store is not cleared.
module sparse_row_packed_dot_accumulator #(
    parameter int VECTOR_DEPTH = srpda_pkg::VECTOR_DEPTH_DEF,
    parameter int ACC_WIDTH    = srpda_pkg::ACC_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: precision_mode
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [9:0] index, [17:10] data, [23:18] zero
    input  logic [1:0]  s_tuser,   // [1:0] func
    input  logic        s_tlast,   // row_end
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] row_sum
);
    import srpda_pkg::*;

    logic [MODE_W-1:0]  precision_mode_reg;
    logic [QCNT_W-1:0]  q_count;
    srpda_entry_t       push;
    srpda_entry_t       head;
    logic               pop;

    // Mode register: a write is always taken. The user must write it only while the
    // block is drained (the block does not enforce this); the back end reads the mode directly.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            precision_mode_reg <= MODE_INT8;
        end else if (cfg_valid && cfg_ready) begin
            precision_mode_reg <= cfg_data;
        end
    end

    // Front end: stage A holds the item and its quotient by the store depth
    // (reciprocal multiply) and issues the store write or read at the remainder;
    // stage B holds the operation, and the read byte joins it on the way into the
    // queue. Loads and the unused code end in the front end and never reach the queue.
    srpda_front #(
        .VECTOR_DEPTH (VECTOR_DEPTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_func  (s_tuser),
        .in_index (s_tdata[9:0]),
        .in_data  (s_tdata[17:10]),
        .in_last  (s_tlast),
        .q_count  (q_count),
        .push     (push)
    );

    // The queue absorbs the front end pipeline while the output is stalled;
    // the front end stops taking transfers when in-flight items could fill it.
    srpda_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .head    (head),
        .count   (q_count)
    );

    // Back end: multiply, accumulate, and hold the finished row in the output
    // register. Non-final nonzeros keep flowing even while a result waits.
    srpda_back #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .mode     (precision_mode_reg),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

FILE: hw/rtl/srpda_checker.sv
// Port level checker of the sparse row dot accumulator, bound to the top level.
module srpda_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // a stalled result holds its value until transferred
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    // reset empties the output register
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a drained block takes an item in the first cycle after reset
    a_ready_after_reset: assert property (@(posedge aclk)
        !aresetn ##1 aresetn |-> s_tready)
        else $error("input not ready after reset");

    // the mode register never stalls a write
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind sparse_row_packed_dot_accumulator srpda_checker u_srpda_checker (.*);
